// ===== hw/rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, lexer mode codes and result helpers for the token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  // Lexer modes.
  localparam logic [2:0] MODE_SKIP     = 3'd0;
  localparam logic [2:0] MODE_SLASH    = 3'd1;
  localparam logic [2:0] MODE_COMMENT  = 3'd2;
  localparam logic [2:0] MODE_WORD     = 3'd3;
  localparam logic [2:0] MODE_QUOTE    = 3'd4;
  localparam logic [2:0] MODE_QUOTE_BS = 3'd5;
  localparam logic [2:0] MODE_DONE     = 3'd6;

  // Character codes.
  localparam logic [7:0] CHR_NUL     = 8'h00;
  localparam logic [7:0] CHR_LF      = 8'h0a;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_QUOTE   = 8'h22;
  localparam logic [7:0] CHR_SLASH   = 8'h2f;
  localparam logic [7:0] CHR_BSLASH  = 8'h5c;

  // Depth of the result queue; one byte may give two results.
  localparam int unsigned FIFO_DEPTH = 4;

  // One result item.
  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_end;
    logic       discarded;
    logic [7:0] token_length;
    logic       was_quoted;
  } stl_result_t;

  // Whitespace and control bytes, and the whole upper half, delimit words.
  function automatic logic is_delim(input logic [7:0] b);
    return (b <= CHR_SPACE) || b[7];
  endfunction

  // A result that carries one token character.
  function automatic stl_result_t put_byte(input logic [7:0] b);
    stl_result_t r;
    r              = '0;
    r.token_byte   = b;
    return r;
  endfunction

  // A result that closes the current token.
  function automatic stl_result_t put_end(input logic       disc,
                                          input logic [7:0] len,
                                          input logic       quoted);
    stl_result_t r;
    r              = '0;
    r.token_end    = 1'b1;
    r.discarded    = disc;
    r.token_length = len;
    r.was_quoted   = quoted;
    return r;
  endfunction

endpackage

// ===== hw/rtl/stl_in_if.sv =====
// ----------------------------------------------------------------------------
// stl_in_if
// Input channel: one text byte per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hw/rtl/stl_out_if.sv =====
// ----------------------------------------------------------------------------
// stl_out_if
// Result channel: one token character or one end mark per item.
// ----------------------------------------------------------------------------
interface stl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       token_end;
  logic       discarded;
  logic [7:0] token_length;
  logic       was_quoted;

  modport source (output valid, output token_byte, output token_end, output discarded,
                  output token_length, output was_quoted, input ready);
  modport sink   (input valid, input token_byte, input token_end, input discarded,
                  input token_length, input was_quoted, output ready);
endinterface

// ===== hw/rtl/script_token_lexer_core.sv =====
// ----------------------------------------------------------------------------
// script_token_lexer_core
// Streaming lexer that cuts script text into word and quoted-string tokens.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle and updates its mode and character
// count in the same cycle, so a new byte can be accepted every clock. Each
// byte gives zero, one or two result items, which go into a four-entry
// result queue that the output drains at one item per cycle while its ready
// is high; the input is held off whenever fewer than two queue slots are
// free. Token characters come out as they are found, followed by an end item
// with the length and flags. After a zero byte all further bytes are taken
// and ignored until reset.
module script_token_lexer_core #(
  parameter int unsigned MAX_TOKEN_LEN = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if.sink    in_ch,
  stl_out_if.source out_ch
);
  import stl_pkg::*;

  localparam int unsigned CW = $clog2(MAX_TOKEN_LEN + 1);

  logic [2:0]    mode_r;
  logic [2:0]    mode_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [1:0]    n_res;
  logic [1:0]    push_cnt;
  logic          accept;
  logic          can_take_two;
  logic          not_empty;
  stl_result_t   res0;
  stl_result_t   res1;
  stl_result_t   head;

  // Byte decode.
  stl_step #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .CW            (CW)
  ) u_step (
    .mode      (mode_r),
    .count     (count_r),
    .in_byte   (in_ch.in_byte),
    .mode_nxt  (mode_nxt),
    .count_nxt (count_nxt),
    .n_res     (n_res),
    .res0      (res0),
    .res1      (res1)
  );

  // Input handshake.
  assign in_ch.ready = can_take_two;
  assign accept      = in_ch.valid && can_take_two;
  assign push_cnt    = accept ? n_res : 2'd0;

  // Lexer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SKIP;
      count_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

  // Result queue.
  stl_result_fifo u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_cnt     (push_cnt),
    .push0        (res0),
    .push1        (res1),
    .pop          (out_ch.ready),
    .can_take_two (can_take_two),
    .not_empty    (not_empty),
    .head         (head)
  );

  // Output channel.
  assign out_ch.valid        = not_empty;
  assign out_ch.token_byte   = head.token_byte;
  assign out_ch.token_end    = head.token_end;
  assign out_ch.discarded    = head.discarded;
  assign out_ch.token_length = head.token_length;
  assign out_ch.was_quoted   = head.was_quoted;

endmodule

// ===== hw/rtl/stl_step.sv =====
// ----------------------------------------------------------------------------
// stl_step
// Decodes one text byte against the current mode and count, giving the next
// mode, the next count and up to two result items.
// ----------------------------------------------------------------------------
module stl_step #(
  parameter int unsigned MAX_TOKEN_LEN = 128,
  parameter int unsigned CW            = $clog2(MAX_TOKEN_LEN + 1)
) (
  input  logic [2:0]          mode,
  input  logic [CW-1:0]       count,
  input  logic [7:0]          in_byte,
  output logic [2:0]          mode_nxt,
  output logic [CW-1:0]       count_nxt,
  output logic [1:0]          n_res,
  output stl_pkg::stl_result_t res0,
  output stl_pkg::stl_result_t res1
);
  import stl_pkg::*;

  localparam logic [CW-1:0] MAX_C = CW'(MAX_TOKEN_LEN);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [CW-1:0]  c;
  logic [CW+7:0]  c_ext;
  logic [2:0]     m;
  logic [1:0]     k;
  logic           wa;
  logic           wf;
  logic           qb;
  logic           disc;
  stl_result_t    r [2];

  always_comb begin
    c    = count;
    m    = mode;
    k    = 2'd0;
    wa   = 1'b0;
    wf   = 1'b0;
    qb   = 1'b0;
    disc = 1'b0;
    r[0] = '0;
    r[1] = '0;

    // Mode-specific handling; shared word and quote steps follow below.
    case (mode)
      MODE_SKIP: begin
        if (in_byte == CHR_NUL) begin
          m = MODE_DONE;
        end else if (is_delim(in_byte)) begin
          m = MODE_SKIP;
        end else if (in_byte == CHR_SLASH) begin
          m = MODE_SLASH;
        end else if (in_byte == CHR_QUOTE) begin
          c = '0;
          m = MODE_QUOTE;
        end else begin
          c  = '0;
          wa = 1'b1;
          m  = MODE_WORD;
        end
      end
      MODE_SLASH: begin
        if (in_byte == CHR_SLASH) begin
          m = MODE_COMMENT;
        end else begin
          // The held slash opens a word; the minimum length keeps it stored.
          c    = ONE_C;
          r[0] = put_byte(CHR_SLASH);
          k    = 2'd1;
          m    = MODE_WORD;
          if (is_delim(in_byte)) begin
            wf = 1'b1;
          end else begin
            wa = 1'b1;
          end
        end
      end
      MODE_COMMENT: begin
        if (in_byte == CHR_NUL) begin
          m = MODE_DONE;
        end else if (in_byte == CHR_LF) begin
          m = MODE_SKIP;
        end
      end
      MODE_WORD: begin
        if (is_delim(in_byte)) begin
          wf = 1'b1;
        end else begin
          wa = 1'b1;
        end
      end
      MODE_QUOTE: begin
        qb = 1'b1;
      end
      MODE_QUOTE_BS: begin
        if (in_byte == CHR_QUOTE) begin
          if (c < MAX_C - ONE_C) begin
            c       = c + ONE_C;
            r[k[0]] = put_byte(CHR_QUOTE);
            k       = k + 2'd1;
          end
          m = MODE_QUOTE;
        end else begin
          // The backslash stands for itself, then the byte is handled as usual.
          if (c < MAX_C - ONE_C) begin
            c       = c + ONE_C;
            r[k[0]] = put_byte(CHR_BSLASH);
            k       = k + 2'd1;
          end
          qb = 1'b1;
        end
      end
      default: begin
        m = MODE_DONE;
      end
    endcase

    // Add one character to a word, dropping it beyond the maximum length.
    if (wa) begin
      if (c < MAX_C) begin
        c       = c + ONE_C;
        r[k[0]] = put_byte(in_byte);
        k       = k + 2'd1;
      end
    end

    // Close a word; one that reached the maximum length is flagged as dropped.
    if (wf) begin
      disc    = (c == MAX_C);
      c_ext   = {8'd0, c};
      r[k[0]] = put_end(disc, disc ? 8'd0 : c_ext[7:0], 1'b0);
      k       = k + 2'd1;
      c       = '0;
      m       = (in_byte == CHR_NUL) ? MODE_DONE : MODE_SKIP;
    end else begin
      c_ext = {8'd0, c};
    end

    // One byte inside a quoted string.
    if (qb) begin
      if (in_byte == CHR_QUOTE || in_byte == CHR_NUL) begin
        c_ext   = {8'd0, c};
        r[k[0]] = put_end(1'b0, c_ext[7:0], 1'b1);
        k       = k + 2'd1;
        c       = '0;
        m       = (in_byte == CHR_NUL) ? MODE_DONE : MODE_SKIP;
      end else if (in_byte == CHR_BSLASH) begin
        m = MODE_QUOTE_BS;
      end else begin
        if (c < MAX_C - ONE_C) begin
          c       = c + ONE_C;
          r[k[0]] = put_byte(in_byte);
          k       = k + 2'd1;
        end
        m = MODE_QUOTE;
      end
    end

    mode_nxt  = m;
    count_nxt = c;
    n_res     = k;
    res0      = r[0];
    res1      = r[1];
  end

endmodule

// ===== hw/rtl/stl_result_fifo.sv =====
// ----------------------------------------------------------------------------
// stl_result_fifo
// Small result queue that takes up to two items per cycle and gives one.
// ----------------------------------------------------------------------------
module stl_result_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  stl_pkg::stl_result_t push0,
  input  stl_pkg::stl_result_t push1,
  input  logic                 pop,
  output logic                 can_take_two,
  output logic                 not_empty,
  output stl_pkg::stl_result_t head
);
  import stl_pkg::*;

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned NW = $clog2(FIFO_DEPTH + 1);

  stl_result_t   entry_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [NW-1:0] fill_r;
  logic [NW-1:0] fill_nxt;
  logic          do_pop;

  // Status towards the producer and consumer.
  assign not_empty    = (fill_r != '0);
  assign can_take_two = (fill_r <= NW'(FIFO_DEPTH - 2));
  assign head         = entry_r[rd_ptr_r];
  assign do_pop       = pop && not_empty;

  // Pointer and fill updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(do_pop);
    fill_nxt   = fill_r + NW'(push_cnt) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage; the second item of a pair lands one slot further on.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entry_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      entry_r[wr_ptr_r + PW'(1)] <= push1;
    end
  end

endmodule
